/* hdl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int LEN_OUT_W   = 16;
   localparam int CAP_W       = 16;
   localparam int CMP_W       = (LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

   localparam logic [6:0] CODE_PLUS  = 7'h3e;
   localparam logic [6:0] CODE_SLASH = 7'h3f;
   localparam logic [6:0] CODE_NONE  = 7'h40;
   localparam logic [6:0] DIGIT_BASE = 7'h34;
   localparam logic [6:0] LOWER_BASE = 7'h1a;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2,
      PH_FOURTH = 2'd3
   } phase_type;

   // classified character passed from front to back
   typedef struct packed {
      logic [5:0] sextet;
      logic       bad;
      logic       last;
   } char_item_type;

   // bit 6 set means the byte is outside the alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] code;
      code = CODE_NONE;
      if (c >= 8'h41 && c <= 8'h5a) begin
         code = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         code = 7'(c - 8'h61) + LOWER_BASE;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         code = 7'(c - 8'h30) + DIGIT_BASE;
      end else if (c == 8'h2b) begin
         code = CODE_PLUS;
      end else if (c == 8'h2f) begin
         code = CODE_SLASH;
      end
      return code;
   endfunction

endpackage

/* hdl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts request characters, maps them to sextets and pushes them to the queue.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic                    req_valid,
   input  logic [7:0]              req_code_char,
   input  logic                    req_last_char,
   output logic                    req_stall,
   input  logic                    q_full,
   output logic                    q_push,
   output b64d_pkg::char_item_type q_item
);

   logic [6:0] code;

   always_comb begin
      code          = b64d_pkg::sextet_of(req_code_char);
      req_stall     = q_full;
      q_push        = req_valid & ~q_full;
      q_item.sextet = code[5:0];
      q_item.bad    = code[6];
      q_item.last   = req_last_char;
   end

endmodule

/* hdl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Short FIFO between the classifying front and the decoding back.
// ----------------------------------------------------------------------------
module b64d_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  b64d_pkg::char_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output b64d_pkg::char_item_type pop_item
);

   b64d_pkg::char_item_type                entry_ff [b64d_pkg::QUEUE_DEPTH];
   logic [b64d_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                                   do_pop;

   localparam logic [b64d_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      b64d_pkg::QUEUE_PTR_W'(b64d_pkg::QUEUE_DEPTH - 1);
   localparam logic [b64d_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      b64d_pkg::QUEUE_CNT_W'(b64d_pkg::QUEUE_DEPTH);

   always_comb begin
      full      = (count_ff == FULL_CNT);
      pop_valid = (count_ff != '0);
      pop_item  = entry_ff[rd_ptr_ff];
      do_pop    = pop & pop_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Running decode state, capacity check and the registered response stage.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data,
   input  logic                    q_valid,
   input  b64d_pkg::char_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_byte_out,
   output logic                    rsp_byte_valid,
   output logic                    rsp_done_res,
   output logic [15:0]             rsp_decoded_length,
   output logic                    rsp_halted_early
);

   localparam int LB = b64d_pkg::LENGTH_BITS;
   localparam int CW = b64d_pkg::CMP_W;
   localparam logic [LB-1:0] COUNT_MAX = {LB{1'b1}};

   logic [b64d_pkg::CAP_W-1:0] capacity_ff;
   b64d_pkg::phase_type        phase_ff, phase_in;
   logic [7:0]                 partial_ff, partial_in;
   logic [LB-1:0]              count_ff, count_in;
   logic                       halted_ff, halted_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       bvalid_ff, bvalid_in;
   logic                       done_ff, done_in;
   logic [15:0]                len_ff, len_in;
   logic                       early_ff, early_in;

   logic                       take;
   logic [CW-1:0]              cap_ext, max_ext, cap_eff, cnt_ext, new_ext;
   logic [5:0]                 s;

   always_comb begin
      take    = q_valid & (~rsp_valid_ff | ~rsp_stall);
      q_pop   = take;
      s       = q_item.sextet;
      cap_ext = CW'(capacity_ff);
      max_ext = CW'(COUNT_MAX);
      cap_eff = (cap_ext < max_ext) ? cap_ext : max_ext;
      cnt_ext = CW'(count_ff);

      phase_in   = phase_ff;
      partial_in = partial_ff;
      count_in   = count_ff;
      halted_in  = halted_ff;
      byte_in    = 8'h00;
      bvalid_in  = 1'b0;

      if (!halted_ff) begin
         if (q_item.bad || cnt_ext >= cap_eff) begin
            halted_in = 1'b1;
         end else begin
            case (phase_ff)
               b64d_pkg::PH_FIRST: begin
                  partial_in = {s, 2'b00};
               end
               b64d_pkg::PH_SECOND: begin
                  byte_in    = partial_ff | {6'h00, s[5:4]};
                  partial_in = {s[3:0], 4'h0};
                  bvalid_in  = 1'b1;
               end
               b64d_pkg::PH_THIRD: begin
                  byte_in    = partial_ff | {4'h0, s[5:2]};
                  partial_in = {s[1:0], 6'h00};
                  bvalid_in  = 1'b1;
               end
               default: begin
                  byte_in    = partial_ff | {2'b00, s};
                  partial_in = 8'h00;
                  bvalid_in  = 1'b1;
               end
            endcase
            phase_in = b64d_pkg::phase_type'(phase_ff + 2'd1);
            if (bvalid_in) begin
               count_in = count_ff + 1'b1;
            end
         end
      end

      new_ext  = CW'(count_in);
      done_in  = q_item.last;
      len_in   = q_item.last ? new_ext[15:0] : 16'h0000;
      early_in = q_item.last & halted_in;

      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_valid          = rsp_valid_ff;
      rsp_byte_out       = byte_ff;
      rsp_byte_valid     = bvalid_ff;
      rsp_done_res       = done_ff;
      rsp_decoded_length = len_ff;
      rsp_halted_early   = early_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= b64d_pkg::CAP_RESET;
         phase_ff     <= b64d_pkg::PH_FIRST;
         partial_ff   <= 8'h00;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            if (q_item.last) begin
               phase_ff   <= b64d_pkg::PH_FIRST;
               partial_ff <= 8'h00;
               count_ff   <= '0;
               halted_ff  <= 1'b0;
            end else begin
               phase_ff   <= phase_in;
               partial_ff <= partial_in;
               count_ff   <= count_in;
               halted_ff  <= halted_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         done_ff   <= done_in;
         len_ff    <= len_in;
         early_ff  <= early_in;
      end
   end

endmodule

/* hdl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder, one character per request, one response each.
// A request accept writes the queue; the back end then decodes the character into
// the output register, where the response becomes valid.
// Throughput: 1 character per cycle while rsp_stall is low; a held response
// backs up the queue and then stalls requests. Synchronous active-high reset
// empties the queue, clears the decode state and sets output_capacity to 65535.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_char,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_byte_valid,
   output logic        rsp_done_res,
   output logic [15:0] rsp_decoded_length,
   output logic        rsp_halted_early
);

   logic                    q_full;
   logic                    q_push;
   b64d_pkg::char_item_type q_push_item;
   logic                    q_pop;
   logic                    q_valid;
   b64d_pkg::char_item_type q_item;

   b64d_front u_front (
      .req_valid     (req_valid),
      .req_code_char (req_code_char),
      .req_last_char (req_last_char),
      .req_stall     (req_stall),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_push_item)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   b64d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_done_res       (rsp_done_res),
      .rsp_decoded_length (rsp_decoded_length),
      .rsp_halted_early   (rsp_halted_early)
   );

endmodule
